/* src/ptom_pkg.sv */
// Shared types and constants for the price-time order matching block.
package ptom_pkg;
    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;
    localparam logic SIDE_SELL  = 1'b1;

    // Shift commands that every cell of one side's book obeys in a cycle.
    typedef struct packed {
        logic pop;      // shift toward head, drop head
        logic ins;      // insert new entry at the first "worse" slot
        logic dec;      // reduce head quantity
        logic sell;     // side of the book: 1 ask (lower is better)
    } t_book_cmd;
endpackage

/* src/ptom_cell.sv */
// One slot of a sorted book: holds price, quantity and a valid flag.
module ptom_cell #(
    parameter int PRICE_BITS    = 20,
    parameter int QUANTITY_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptom_pkg::t_book_cmd      i_cmd,
    input  logic [PRICE_BITS-1:0]    i_new_price,
    input  logic [QUANTITY_BITS-1:0] i_new_qty,
    input  logic [QUANTITY_BITS-1:0] i_dec_qty,
    input  logic                     i_is_head,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_worse,
    input  logic [PRICE_BITS-1:0]    i_prev_price,
    input  logic [QUANTITY_BITS-1:0] i_prev_qty,
    input  logic                     i_next_valid,
    input  logic [PRICE_BITS-1:0]    i_next_price,
    input  logic [QUANTITY_BITS-1:0] i_next_qty,
    output logic                     o_valid,
    output logic                     o_worse,
    output logic [PRICE_BITS-1:0]    o_price,
    output logic [QUANTITY_BITS-1:0] o_qty
);
    logic                     r_valid;
    logic [PRICE_BITS-1:0]    r_price;
    logic [QUANTITY_BITS-1:0] r_qty;
    logic                     prev_worse_eff;

    // The new order beats this entry: it must sit in front of it.
    assign o_worse = r_valid && (i_cmd.sell ? (i_new_price < r_price)
                                            : (i_new_price > r_price));
    assign o_valid = r_valid;
    assign o_price = r_price;
    assign o_qty   = r_qty;
    assign prev_worse_eff = i_is_head ? 1'b0 : i_prev_worse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_valid <= i_next_valid;
            r_price <= i_next_price;
            r_qty   <= i_next_qty;
        end else if (i_cmd.ins) begin
            if (prev_worse_eff) begin
                // shift back behind the previous slot
                r_valid <= i_prev_valid;
                r_price <= i_prev_price;
                r_qty   <= i_prev_qty;
            end else if (o_worse || (!r_valid && (i_is_head || i_prev_valid))) begin
                r_valid <= 1'b1;
                r_price <= i_new_price;
                r_qty   <= i_new_qty;
            end
        end else if (i_cmd.dec && i_is_head) begin
            r_qty <= r_qty - i_dec_qty;
        end
    end
endmodule

/* src/ptom_book.sv */
// One side's book: a chain of cells kept sorted in price-time order.
module ptom_book #(
    parameter int ORDER_SLOTS   = 32,
    parameter int PRICE_BITS    = 20,
    parameter int QUANTITY_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptom_pkg::t_book_cmd      i_cmd,
    input  logic [PRICE_BITS-1:0]    i_new_price,
    input  logic [QUANTITY_BITS-1:0] i_new_qty,
    input  logic [QUANTITY_BITS-1:0] i_dec_qty,
    output logic                     o_head_valid,
    output logic [PRICE_BITS-1:0]    o_head_price,
    output logic [QUANTITY_BITS-1:0] o_head_qty,
    output logic                     o_full
);
    logic [ORDER_SLOTS-1:0]    v, w;
    logic [PRICE_BITS-1:0]     p [ORDER_SLOTS];
    logic [QUANTITY_BITS-1:0]  q [ORDER_SLOTS];

    for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_cell
        localparam int PK = (k == 0) ? 0 : k - 1;
        localparam int NK = (k == ORDER_SLOTS - 1) ? k : k + 1;
        ptom_cell #(.PRICE_BITS(PRICE_BITS), .QUANTITY_BITS(QUANTITY_BITS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
            .i_new_price(i_new_price), .i_new_qty(i_new_qty), .i_dec_qty(i_dec_qty),
            .i_is_head(k == 0),
            .i_prev_valid(v[PK]), .i_prev_worse(w[PK]),
            .i_prev_price(p[PK]), .i_prev_qty(q[PK]),
            .i_next_valid((k == ORDER_SLOTS - 1) ? 1'b0 : v[NK]),
            .i_next_price(p[NK]), .i_next_qty(q[NK]),
            .o_valid(v[k]), .o_worse(w[k]), .o_price(p[k]), .o_qty(q[k])
        );
    end

    assign o_head_valid = v[0];
    assign o_head_price = p[0];
    assign o_head_qty   = q[0];
    assign o_full       = v[ORDER_SLOTS-1];
endmodule

/* src/price_time_order_matching.sv */
// Top level: limit order book with price-time matching over two cell chains.
// Results: one trade item per fill, then one done item; each result is registered
// from the match-state cycle that produced it.
// Throughput: set by the one-fill-per-cycle walk; busy is high for the walk
// and drops as the done item is strobed.
// Reset (synchronous, i_rst_n low) empties both books and ends any run; no stall.
module price_time_order_matching #(
    parameter int ORDER_SLOTS   = 32,
    parameter int PRICE_BITS    = 20,
    parameter int QUANTITY_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_side,
    input  logic [PRICE_BITS-1:0]    i_limit_price,
    input  logic [QUANTITY_BITS-1:0] i_order_quantity,
    output logic                     o_valid,
    output logic                     o_kind,
    output logic [QUANTITY_BITS-1:0] o_trade_quantity,
    output logic [PRICE_BITS-1:0]    o_trade_price,
    output logic [QUANTITY_BITS-1:0] o_rested_quantity,
    output logic                     o_book_full,
    output logic                     o_last
);
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MATCH = 2'b10
    } t_state;

    t_state                   r_state;
    logic                     r_sell;
    logic [PRICE_BITS-1:0]    r_price;
    logic [QUANTITY_BITS-1:0] r_rem;

    ptom_pkg::t_book_cmd      bid_cmd, ask_cmd;
    logic                     bid_hv, ask_hv, bid_full, ask_full;
    logic [PRICE_BITS-1:0]    bid_hp, ask_hp;
    logic [QUANTITY_BITS-1:0] bid_hq, ask_hq;

    // opposite-side head as seen by the active order
    logic                     opp_v, crosses, fill, own_full;
    logic [PRICE_BITS-1:0]    opp_p;
    logic [QUANTITY_BITS-1:0] opp_q, fill_q;

    assign opp_v    = r_sell ? bid_hv : ask_hv;
    assign opp_p    = r_sell ? bid_hp : ask_hp;
    assign opp_q    = r_sell ? bid_hq : ask_hq;
    assign own_full = r_sell ? ask_full : bid_full;
    assign crosses  = r_sell ? (r_price <= opp_p) : (r_price >= opp_p);
    assign fill     = (r_state == ST_MATCH) && (r_rem != '0) && opp_v && crosses;
    assign fill_q   = (r_rem < opp_q) ? r_rem : opp_q;

    logic done_now, rest_now;
    assign done_now = (r_state == ST_MATCH) && !fill;
    assign rest_now = done_now && (r_rem != '0) && !own_full;

    always_comb begin
        // fill hits the opposite book; rest goes into the own book
        bid_cmd      = '0;
        ask_cmd      = '0;
        bid_cmd.sell = ptom_pkg::SIDE_BUY;
        ask_cmd.sell = ptom_pkg::SIDE_SELL;
        if (fill) begin
            if (r_sell) begin
                bid_cmd.pop = (fill_q == bid_hq);
                bid_cmd.dec = 1'b1;
            end else begin
                ask_cmd.pop = (fill_q == ask_hq);
                ask_cmd.dec = 1'b1;
            end
        end else if (rest_now) begin
            if (r_sell) ask_cmd.ins = 1'b1;
            else        bid_cmd.ins = 1'b1;
        end
    end

    ptom_book #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS),
                .QUANTITY_BITS(QUANTITY_BITS)) u_bids (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(bid_cmd),
        .i_new_price(r_price), .i_new_qty(r_rem), .i_dec_qty(fill_q),
        .o_head_valid(bid_hv), .o_head_price(bid_hp), .o_head_qty(bid_hq),
        .o_full(bid_full)
    );

    ptom_book #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS),
                .QUANTITY_BITS(QUANTITY_BITS)) u_asks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(ask_cmd),
        .i_new_price(r_price), .i_new_qty(r_rem), .i_dec_qty(fill_q),
        .o_head_valid(ask_hv), .o_head_price(ask_hp), .o_head_qty(ask_hq),
        .o_full(ask_full)
    );

    assign busy = (r_state != ST_IDLE);

    // Control: latch the order, walk fills, then close with the done item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            // strobe one result for every cycle spent matching
            o_valid <= (r_state == ST_MATCH);
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_sell  <= i_side;
                        r_price <= i_limit_price;
                        r_rem   <= i_order_quantity;
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    if (fill) begin
                        r_rem <= r_rem - fill_q;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result payload: trade fields on a fill, summary fields on done.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MATCH) begin
            o_kind            <= fill ? ptom_pkg::KIND_TRADE : ptom_pkg::KIND_DONE;
            o_trade_quantity  <= fill ? fill_q : '0;
            o_trade_price     <= fill ? opp_p : '0;
            o_rested_quantity <= rest_now ? r_rem : '0;
            o_book_full       <= done_now && (r_rem != '0) && own_full;
            o_last            <= done_now;
        end
    end
endmodule
